// ===== sv/wsfr_pkg.sv =====
// wsfr_pkg: types and constants for the WebSocket frame receiver.
// No dependencies.
package wsfr_pkg;

    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_MSG_DONE  = 3'd1;
    localparam logic [2:0] ST_FRAME_CON = 3'd2;
    localparam logic [2:0] ST_CLOSE_OK  = 3'd3;
    localparam logic [2:0] ST_CLOSE_NC  = 3'd4;
    localparam logic [2:0] ST_CLOSE_PE  = 3'd5;
    localparam logic [2:0] ST_CLOSE_BIG = 3'd6;

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic CFG_MAX_FRAME = 1'b0;
    localparam logic CFG_MAX_MSG   = 1'b1;

    // one result item
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       message_binary;
        logic [2:0] status;
    } wsfr_result_t;

    function automatic logic close_code_ok(input logic [15:0] code);
        return (code >= 16'd1000 && code <= 16'd1003) ||
               (code >= 16'd1007 && code <= 16'd1011) ||
               (code >= 16'd3000 && code <= 16'd4999);
    endfunction

endpackage

// ===== sv/wsfr_parser.sv =====
// wsfr_parser: front part; byte-wise header parser, unmasking and verdicts.
// Depends on wsfr_pkg.
module wsfr_parser import wsfr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    input  logic [31:0]  max_frame_bytes,
    input  logic [31:0]  max_message_bytes,
    output logic         res_valid,
    output wsfr_result_t res
);

    logic [3:0]  pos_reg,  pos_next;
    logic [7:0]  fhb_reg,  fhb_next;
    logic [6:0]  lcode_reg, lcode_next;
    logic [31:0] plen_reg, plen_next;
    logic        ovf_reg,  ovf_next;
    logic [31:0] pcnt_reg, pcnt_next;
    logic [31:0] key_reg,  key_next;
    logic        mact_reg, mact_next;
    logic        mbin_reg, mbin_next;
    logic [31:0] mlen_reg, mlen_next;
    logic [7:0]  cch_reg,  cch_next;
    logic        halt_reg, halt_next;

    logic [3:0]  hlen;
    logic [3:0]  op;
    logic        fin;
    logic        emit;
    wsfr_result_t r;
    // header check inputs
    logic        hc_do;
    logic [31:0] hc_len;
    logic        hc_ovf;
    logic        fe_do;
    logic        fe_valid;
    logic [7:0]  fe_byte;
    logic [7:0]  u;
    logic [32:0] fsum, msum;
    logic [3:0]  pos_off;

    always_comb begin
        hlen = (lcode_reg == LEN_EXT16) ? 4'd8 : (lcode_reg == LEN_EXT64) ? 4'd14 : 4'd6;
        pos_next = pos_reg; fhb_next = fhb_reg; lcode_next = lcode_reg;
        plen_next = plen_reg; ovf_next = ovf_reg; pcnt_next = pcnt_reg;
        key_next = key_reg; mact_next = mact_reg; mbin_next = mbin_reg;
        mlen_next = mlen_reg; cch_next = cch_reg; halt_next = halt_reg;
        emit = 1'b0;
        r = '0;
        hc_do = 1'b0; hc_len = plen_reg; hc_ovf = ovf_reg;
        fe_do = 1'b0; fe_valid = 1'b0; fe_byte = 8'd0;
        op = fhb_reg[3:0];
        fin = fhb_reg[7];
        u = 8'd0;
        pos_off = 4'd0;
        fsum = '0; msum = '0;
        if (in_valid && !halt_reg) begin
            if (pos_reg == 4'd0) begin
                fhb_next = in_byte; lcode_next = '0; plen_next = '0;
                ovf_next = 1'b0; pcnt_next = '0; key_next = '0;
                if ((in_byte & 8'h70) != 8'd0) begin
                    emit = 1'b1; r.status = ST_CLOSE_PE;
                end else begin
                    pos_next = 4'd1;
                end
            end else if (pos_reg == 4'd1) begin
                if (!in_byte[7]) begin
                    emit = 1'b1; r.status = ST_CLOSE_PE;
                end else begin
                    lcode_next = in_byte[6:0];
                    plen_next = (in_byte[6:0] < LEN_EXT16) ? {25'd0, in_byte[6:0]} : 32'd0;
                    pos_next = 4'd2;
                    hlen = 4'd6;
                    if (in_byte[6:0] < LEN_EXT16) begin
                        hc_do = 1'b1; hc_len = {25'd0, in_byte[6:0]};
                    end
                end
            end else if (pos_reg < hlen - 4'd4) begin
                if (lcode_reg == LEN_EXT64 && pos_reg < 4'd6) begin
                    if (in_byte != 8'd0) ovf_next = 1'b1;
                end else begin
                    plen_next = {plen_reg[23:0], in_byte};
                end
                pos_next = pos_reg + 4'd1;
                hc_len = plen_next; hc_ovf = ovf_next;
                if (pos_reg == hlen - 4'd5) hc_do = 1'b1;
            end else if (pos_reg < hlen) begin
                pos_off = pos_reg - (hlen - 4'd4);
                key_next[8*pos_off[1:0] +: 8] = in_byte;
                pos_next = pos_reg + 4'd1;
                if (pos_reg == hlen - 4'd1 && plen_reg == 32'd0) fe_do = 1'b1;
            end else begin
                u = in_byte ^ key_reg[8*pcnt_reg[1:0] +: 8];
                if (pcnt_reg == 32'd0) cch_next = u;
                pcnt_next = pcnt_reg + 32'd1;
                if ({1'b0, pcnt_reg} + 33'd1 >= {1'b0, plen_reg}) begin
                    fe_do = 1'b1; fe_valid = (op <= OP_BIN); fe_byte = u;
                end else if (op <= OP_BIN) begin
                    emit = 1'b1; r.payload_valid = 1'b1; r.payload_byte = u;
                    r.message_binary = mbin_reg;
                end
            end
            // header verdict once the length is known
            if (hc_do) begin
                fsum = {29'd0, hlen} + {1'b0, hc_len};
                msum = {1'b0, mlen_reg} + {1'b0, hc_len};
                emit = 1'b1;
                if (hc_ovf || fsum > {1'b0, max_frame_bytes}) r.status = ST_CLOSE_BIG;
                else if (op == OP_CONT && !mact_reg) r.status = ST_CLOSE_PE;
                else if ((op == OP_TEXT || op == OP_BIN) && mact_reg) r.status = ST_CLOSE_PE;
                else if ((op == OP_CLOSE || op == OP_PING || op == OP_PONG) &&
                         (!fin || hc_len > 32'd125)) r.status = ST_CLOSE_PE;
                else if (op > OP_BIN && op != OP_CLOSE && op != OP_PING && op != OP_PONG)
                    r.status = ST_CLOSE_PE;
                else if (op <= OP_BIN && msum > {1'b0, max_message_bytes})
                    r.status = ST_CLOSE_BIG;
                else if (op == OP_CLOSE && hc_len == 32'd1) r.status = ST_CLOSE_PE;
                else begin
                    emit = 1'b0;
                    if (op <= OP_BIN) begin
                        if (!mact_reg) begin
                            mact_next = 1'b1; mbin_next = (op != OP_TEXT);
                        end
                        mlen_next = msum[31:0];
                    end
                end
            end
            if (fe_do) begin
                pos_next = 4'd0;
                emit = 1'b1;
                r.payload_valid = fe_valid;
                // control payload bytes are never shown
                r.payload_byte = fe_valid ? fe_byte : 8'd0;
                if (op <= OP_BIN) begin
                    r.message_binary = mbin_reg;
                    if (fin) begin
                        r.status = ST_MSG_DONE; mact_next = 1'b0; mlen_next = '0;
                    end else begin
                        r.status = ST_FRAME_CON;
                    end
                end else if (op == OP_CLOSE) begin
                    if (plen_reg == 32'd0) r.status = ST_CLOSE_OK;
                    else if (plen_reg == 32'd2)
                        r.status = close_code_ok({cch_reg, fe_byte}) ? ST_CLOSE_OK : ST_CLOSE_PE;
                    else r.status = ST_CLOSE_NC;
                end else begin
                    r.status = ST_FRAME_CON;
                end
            end
            if (emit && r.status >= ST_CLOSE_OK) halt_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; fhb_reg <= '0; lcode_reg <= '0; plen_reg <= '0;
            ovf_reg <= 1'b0; pcnt_reg <= '0; key_reg <= '0; mact_reg <= 1'b0;
            mbin_reg <= 1'b0; mlen_reg <= '0; cch_reg <= '0; halt_reg <= 1'b0;
            res_valid <= 1'b0;
        end else begin
            pos_reg <= pos_next; fhb_reg <= fhb_next; lcode_reg <= lcode_next;
            plen_reg <= plen_next; ovf_reg <= ovf_next; pcnt_reg <= pcnt_next;
            key_reg <= key_next; mact_reg <= mact_next; mbin_reg <= mbin_next;
            mlen_reg <= mlen_next; cch_reg <= cch_next; halt_reg <= halt_next;
            res_valid <= emit;
        end
        res <= r;
    end

endmodule

// ===== sv/wsfr_queue.sv =====
// wsfr_queue: small result queue between parser and output port.
// Depends on wsfr_pkg.
module wsfr_queue import wsfr_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    input  wsfr_result_t wr_data,
    output logic         free_ok,
    output logic         rd_valid,
    output wsfr_result_t rd_data,
    input  logic         rd_ready
);
    localparam int AW = $clog2(DEPTH);

    wsfr_result_t   mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           rd_fire;

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign rd_fire  = rd_valid && rd_ready;
    // room for one more beyond the result possibly in flight in the parser
    assign free_ok  = (cnt_reg <= (AW+1)'(DEPTH - 2)) ||
                      ((cnt_reg == (AW+1)'(DEPTH - 1)) && rd_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_valid) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_fire)  rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_valid) - (AW+1)'(rd_fire);
        end
        if (wr_valid) mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== sv/websocket_frame_receiver.sv =====
// websocket_frame_receiver: top level; parser front, result queue back.
// Depends on wsfr_pkg, wsfr_parser, wsfr_queue.
//
// Usage:
//  - s_axis: one received stream byte per transfer (tdata[7:0] = frame_byte).
//  - m_axis: result items; tdata = {status, message_binary, payload_byte,
//    payload_valid} from the highest bit down, zero padded to 16 bits.
//  - cfg port: cfg_we writes cfg_wdata to register cfg_addr (0 max frame
//    bytes, 1 max message bytes); other indexes are ignored.
// A result is registered in the parser and then written into the queue,
// from which it is offered on m_axis.
// Throughput: one byte per cycle while s_axis_tready is high.
// Reset (aresetn low, synchronous) clears parser state and queue and sets
// the limits to their defaults. When the receiver stalls the queue fills;
// s_axis_tready drops while fewer than two entries are free, unless one is
// free and an entry leaves in the same cycle, so no result is lost.
// After a close verdict all bytes are taken and dropped until reset.
module websocket_frame_receiver import wsfr_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] payload_valid, [8:1] payload_byte,
                                        // [9] message_binary, [12:10] status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    logic [31:0]  max_frame_reg, max_msg_reg;
    logic         res_valid;
    wsfr_result_t res, q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= 32'd65550;
            max_msg_reg   <= 32'd1048576;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MAX_FRAME: max_frame_reg <= cfg_wdata;
                CFG_MAX_MSG:   max_msg_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    wsfr_parser u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid && s_axis_tready),
        .in_byte(s_axis_tdata),
        .max_frame_bytes(max_frame_reg),
        .max_message_bytes(max_msg_reg),
        .res_valid(res_valid), .res(res)
    );

    wsfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(res_valid), .wr_data(res),
        .free_ok(s_axis_tready),
        .rd_valid(m_axis_tvalid), .rd_data(q_data), .rd_ready(m_axis_tready)
    );

    assign m_axis_tdata = {3'd0, q_data.status, q_data.message_binary,
                           q_data.payload_byte, q_data.payload_valid};
endmodule

// ===== sv/wsfr_checker.sv =====
// wsfr_checker: port-level assertions for websocket_frame_receiver, with bind.
// Depends on websocket_frame_receiver ports only.
module wsfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[12:10] != 3'd7 && m_axis_tdata[15:13] == 3'd0)
        else $error("bad status");
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("payload byte without valid");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready after reset");
endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
